[hw/rtl/bmel_pkg.sv]
package bmel_pkg;

  // Operation codes of an input word.
  localparam logic [2:0] OP_WRITE_NOTE = 3'd0;
  localparam logic [2:0] OP_START      = 3'd1;
  localparam logic [2:0] OP_STOP       = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_TONE       = 3'd4;

  // Configuration register indexes.
  localparam logic REG_CLOCK_HZ    = 1'b0;
  localparam logic REG_TUNE_LENGTH = 1'b1;

  localparam logic [31:0] CLOCK_HZ_RESET = 32'd16000000;

  // Wide enough for any melody length and for table depths below 8192.
  localparam int LEN_W = 13;
  localparam int DIV_STEPS = 32;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_START,
    CMD_STOP,
    CMD_TICK,
    CMD_TONE,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        write_ok;
    logic [7:0]  index;
    logic [15:0] frequency;
    logic [15:0] duration;
    logic [7:0]  loop_target;
  } cmd_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] reload_value;
    logic [15:0] compare_value;
    logic        playing;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_SOUND,
    S_DIV,
    S_PUSH
  } back_state_t;

endpackage

[hw/rtl/bmel_fifo.sv]
module bmel_fifo
  import bmel_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + CW'(1))
    else $error("fifo count did not grow on a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - CW'(1))
    else $error("fifo count did not shrink on a pop");

endmodule

[hw/rtl/bmel_front.sv]
module bmel_front
  import bmel_pkg::*;
#(
  parameter int NOTE_DEPTH = 256
) (
  input  logic [2:0]  operation,
  input  logic [7:0]  note_index,
  input  logic [15:0] note_frequency,
  input  logic [15:0] note_duration,
  input  logic [7:0]  loop_count,
  output cmd_t        cmd
);

  always_comb begin
    cmd.index       = note_index;
    cmd.frequency   = note_frequency;
    cmd.duration    = note_duration;
    // A loop count of zero plays the melody once.
    cmd.loop_target = (loop_count == 8'd0) ? 8'd0 : loop_count - 8'd1;
    cmd.write_ok    = ({5'd0, note_index} < LEN_W'(NOTE_DEPTH));
    unique case (operation)
      OP_WRITE_NOTE: cmd.kind = CMD_WRITE;
      OP_START:      cmd.kind = CMD_START;
      OP_STOP:       cmd.kind = CMD_STOP;
      OP_TICK:       cmd.kind = CMD_TICK;
      OP_TONE:       cmd.kind = CMD_TONE;
      default:       cmd.kind = CMD_NONE;
    endcase
  end

endmodule

[hw/rtl/bmel_back.sv]
module bmel_back
  import bmel_pkg::*;
#(
  parameter int NOTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_empty,
  input  cmd_t        cmd_in,
  output logic        cmd_pop,
  input  logic        res_full,
  output logic        res_push,
  output result_t     res_out,
  input  logic        write_enable,
  input  logic        register_index,
  input  logic [31:0] write_data
);

  localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

  back_state_t state;
  back_state_t state_next;

  cmd_t        cmd_q;
  logic [31:0] clock_hz;
  logic [8:0]  tune_length;
  logic [8:0]  note_position;
  logic [7:0]  loop_position;
  logic [7:0]  loop_target;
  logic        melody_active;
  logic [15:0] ticks_left;
  logic        timing_active;
  logic        tone_on;
  logic [15:0] reload_value;
  logic [15:0] compare_value;

  logic [31:0] note_store [NOTE_DEPTH];
  logic [31:0] rd_data;
  logic [15:0] snd_freq;
  logic [15:0] snd_dur;

  logic [31:0] div_dvd;
  logic [15:0] div_rem;
  logic [15:0] div_quo;
  logic [4:0]  div_cnt;

  logic [LEN_W-1:0] used_len;
  logic             pos_at_end;
  logic             tick_end;
  logic             need_fetch;
  logic [8:0]       fetch_pos;
  logic [LEN_W-1:0] fetch_wide;
  logic [LEN_W-1:0] wr_wide;
  logic             mem_rd;
  logic             mem_we;

  logic [16:0] div_trial;
  logic [16:0] div_diff;
  logic        div_bit;
  logic [15:0] quo_final;
  logic [15:0] reload_calc;
  logic [16:0] half_calc;

  always_comb begin
    used_len = ({4'd0, tune_length} > LEN_W'(NOTE_DEPTH)) ?
               LEN_W'(NOTE_DEPTH) : {4'd0, tune_length};
    pos_at_end = ({4'd0, note_position} >= used_len);
    tick_end   = timing_active && (ticks_left == 16'd1);
    need_fetch = 1'b0;
    fetch_pos  = 9'd0;
    unique case (cmd_q.kind)
      CMD_START: begin
        need_fetch = (used_len != '0);
      end
      CMD_TICK: begin
        if (tick_end && melody_active) begin
          if (pos_at_end) begin
            need_fetch = !(loop_position >= loop_target || used_len == '0);
          end else begin
            need_fetch = 1'b1;
            fetch_pos  = note_position;
          end
        end
      end
      default: begin
        need_fetch = 1'b0;
      end
    endcase
    fetch_wide = {4'd0, fetch_pos};
    wr_wide    = {5'd0, cmd_q.index};
  end

  // Restoring division of the clock by the tone frequency, one bit a cycle.
  always_comb begin
    div_trial   = {div_rem, div_dvd[31]};
    div_bit     = (div_trial >= {1'b0, snd_freq});
    div_diff    = div_trial - {1'b0, snd_freq};
    quo_final   = {div_quo[14:0], div_bit};
    reload_calc = quo_final - 16'd1;
    half_calc   = ({1'b0, reload_calc} + 17'd1) >> 1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!cmd_empty) state_next = S_EXEC;
      S_EXEC: begin
        if (need_fetch) begin
          state_next = S_FETCH;
        end else if (cmd_q.kind == CMD_TONE) begin
          state_next = S_SOUND;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_FETCH: state_next = S_SOUND;
      S_SOUND: state_next = (snd_freq != 16'd0) ? S_DIV : S_PUSH;
      S_DIV:   if (div_cnt == 5'(DIV_STEPS - 1)) state_next = S_PUSH;
      S_PUSH:  if (!res_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state == S_IDLE) && !cmd_empty;
    res_push = (state == S_PUSH) && !res_full;
    mem_rd   = (state == S_EXEC) && need_fetch;
    mem_we   = (state == S_EXEC) && (cmd_q.kind == CMD_WRITE) && cmd_q.write_ok;
    res_out.tone_on       = tone_on;
    res_out.reload_value  = reload_value;
    res_out.compare_value = compare_value;
    res_out.playing       = melody_active;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_store[wr_wide[AW-1:0]] <= {cmd_q.frequency, cmd_q.duration};
    end
    if (mem_rd) begin
      rd_data <= note_store[fetch_wide[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_q <= cmd_in;
    end
    unique case (state)
      S_EXEC: begin
        if (cmd_q.kind == CMD_TONE) begin
          snd_freq <= cmd_q.frequency;
          snd_dur  <= cmd_q.duration;
        end
      end
      S_FETCH: begin
        snd_freq <= rd_data[31:16];
        snd_dur  <= rd_data[15:0];
      end
      S_SOUND: begin
        div_dvd <= clock_hz;
        div_rem <= '0;
        div_quo <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        div_dvd <= {div_dvd[30:0], 1'b0};
        div_rem <= div_bit ? div_diff[15:0] : div_trial[15:0];
        div_quo <= quo_final;
        div_cnt <= div_cnt + 5'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      clock_hz      <= CLOCK_HZ_RESET;
      tune_length   <= '0;
      note_position <= '0;
      loop_position <= '0;
      loop_target   <= '0;
      melody_active <= 1'b0;
      ticks_left    <= '0;
      timing_active <= 1'b0;
      tone_on       <= 1'b0;
      reload_value  <= '0;
      compare_value <= '0;
    end else begin
      state <= state_next;
      if (write_enable) begin
        unique case (register_index)
          REG_CLOCK_HZ:    clock_hz    <= write_data;
          REG_TUNE_LENGTH: tune_length <= write_data[8:0];
          default:         clock_hz    <= clock_hz;
        endcase
      end
      unique case (state)
        S_EXEC: begin
          unique case (cmd_q.kind)
            CMD_START: begin
              tone_on       <= 1'b0;
              reload_value  <= '0;
              compare_value <= '0;
              timing_active <= 1'b0;
              ticks_left    <= '0;
              loop_position <= '0;
              loop_target   <= cmd_q.loop_target;
              melody_active <= need_fetch;
              note_position <= need_fetch ? 9'd1 : 9'd0;
            end
            CMD_STOP: begin
              melody_active <= 1'b0;
              tone_on       <= 1'b0;
              reload_value  <= '0;
              compare_value <= '0;
              timing_active <= 1'b0;
              ticks_left    <= '0;
            end
            CMD_TICK: begin
              // On the last tick the count steps from one to zero.
              if (timing_active) begin
                ticks_left <= ticks_left - 16'd1;
              end
              if (tick_end) begin
                // The note is over; a fetched note restarts the timing.
                timing_active <= 1'b0;
                if (need_fetch) begin
                  if (pos_at_end) begin
                    loop_position <= loop_position + 8'd1;
                    note_position <= 9'd1;
                  end else begin
                    note_position <= note_position + 9'd1;
                  end
                end else begin
                  melody_active <= 1'b0;
                  tone_on       <= 1'b0;
                  reload_value  <= '0;
                  compare_value <= '0;
                end
              end
            end
            CMD_TONE: begin
              melody_active <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        S_SOUND: begin
          ticks_left    <= snd_dur;
          timing_active <= (snd_dur != 16'd0);
          if (snd_freq == 16'd0) begin
            tone_on       <= 1'b0;
            reload_value  <= '0;
            compare_value <= '0;
          end
        end
        S_DIV: begin
          if (div_cnt == 5'(DIV_STEPS - 1)) begin
            tone_on       <= 1'b1;
            reload_value  <= reload_calc;
            compare_value <= half_calc[15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_silent_zero: assert property (@(posedge clk)
    !tone_on |-> (reload_value == 16'd0) && (compare_value == 16'd0))
    else $error("tone off with nonzero PWM values");

  a_timing_count: assert property (@(posedge clk)
    timing_active |-> ticks_left != 16'd0)
    else $error("note timing active with no ticks left");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == 5'(DIV_STEPS - 1)) |=> state == S_PUSH)
    else $error("division did not finish into the result stage");

  a_active_position: assert property (@(posedge clk)
    melody_active |-> note_position != 9'd0)
    else $error("melody running at position zero");

  a_active_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(melody_active) |-> $past(state == S_EXEC && cmd_q.kind == CMD_START))
    else $error("melody started outside a start word");

endmodule

[hw/rtl/pwm_buzzer_melody_sequencer_top.sv]
// Buzzer melody player. Words enter through a queue (push/full) and each
// one gives exactly one result word (empty/pop) showing the PWM state after
// it. A word that starts a sounding note passes from acceptance to its result
// through queue hand-off, a note table read, and a bit-serial division of the
// clock by the tone frequency. A single tone skips the table read. A word that
// moves to a rest skips the division, and other words skip both. Words are
// carried out one at a time; two input words and two results may wait in
// their queues. The note table holds NOTE_DEPTH entries and must be written
// before a melody plays them.
module pwm_buzzer_melody_sequencer_top
  import bmel_pkg::*;
#(
  parameter int NOTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [7:0]  note_index,
  input  logic [15:0] note_frequency,
  input  logic [15:0] note_duration,
  input  logic [7:0]  loop_count,
  output logic        empty,
  input  logic        pop,
  output logic        tone_on,
  output logic [15:0] reload_value,
  output logic [15:0] compare_value,
  output logic        playing,
  input  logic        write_enable,
  input  logic        register_index,
  input  logic [31:0] write_data
);

  cmd_t    cmd_dec;
  cmd_t    cmd_head;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_head;

  bmel_front #(.NOTE_DEPTH(NOTE_DEPTH)) u_front (
    .operation      (operation),
    .note_index     (note_index),
    .note_frequency (note_frequency),
    .note_duration  (note_duration),
    .loop_count     (loop_count),
    .cmd            (cmd_dec)
  );

  bmel_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_dec),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  bmel_back #(.NOTE_DEPTH(NOTE_DEPTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_empty      (cmd_empty),
    .cmd_in         (cmd_head),
    .cmd_pop        (cmd_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res_out        (res_in),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  bmel_fifo #(.W($bits(result_t)), .DEPTH(2)) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head),
    .empty     (empty)
  );

  assign tone_on       = res_head.tone_on;
  assign reload_value  = res_head.reload_value;
  assign compare_value = res_head.compare_value;
  assign playing       = res_head.playing;

endmodule

[dv/pwm_buzzer_melody_sequencer_checker.sv]
`timescale 1ns / 1ps

module pwm_buzzer_melody_sequencer_checker
  import bmel_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  operation,
  input  logic [7:0]  note_index,
  input  logic [15:0] note_frequency,
  input  logic [15:0] note_duration,
  input  logic [7:0]  loop_count,
  input  logic        empty,
  input  logic        pop,
  input  logic        tone_on,
  input  logic [15:0] reload_value,
  input  logic [15:0] compare_value,
  input  logic        playing,
  input  logic        write_enable,
  input  logic        register_index,
  input  logic [31:0] write_data,
  output int          mismatches,
  output int          words_due
);

  localparam int TABLE_DEPTH = 256;

  logic [31:0] note_tbl [TABLE_DEPTH];
  logic [31:0] clk_rate;
  logic [8:0]  tune_len;
  logic [8:0]  next_note;
  logic [7:0]  pass_no;
  logic [7:0]  last_pass;
  logic        in_tune;
  logic [15:0] ticks_rem;
  logic        counting;
  logic        buzz_on;
  logic [15:0] buzz_reload;
  logic [15:0] buzz_cmp;
  result_t     pwm_due_q [$];

  function automatic int notes_in_use();
    return (tune_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(tune_len);
  endfunction

  function automatic void silence();
    buzz_on = 1'b0;
    buzz_reload = '0;
    buzz_cmp = '0;
    counting = 1'b0;
    ticks_rem = '0;
  endfunction

  function automatic void sound_note(logic [15:0] freq, logic [15:0] dur);
    logic [31:0] period;
    if (freq != 16'd0) begin
      period = clk_rate / {16'd0, freq} - 32'd1;
      buzz_reload = period[15:0];
      buzz_cmp = 16'(({1'b0, buzz_reload} + 17'd1) >> 1);
      buzz_on = 1'b1;
    end else begin
      buzz_on = 1'b0;
      buzz_reload = '0;
      buzz_cmp = '0;
    end
    counting = (dur != 16'd0);
    ticks_rem = dur;
  endfunction

  function automatic void play_slot(logic [8:0] slot);
    logic [31:0] entry;
    entry = note_tbl[slot[7:0]];
    sound_note(entry[31:16], entry[15:0]);
  endfunction

  // The current note has run out: step to the next one, wrap for another
  // pass, or fall silent once the passes are used up.
  function automatic void note_done();
    int len;
    len = notes_in_use();
    if (!in_tune) begin
      silence();
      return;
    end
    if (int'(next_note) >= len) begin
      if (pass_no >= last_pass || len == 0) begin
        in_tune = 1'b0;
        silence();
      end else begin
        pass_no = pass_no + 8'd1;
        play_slot(9'd0);
        next_note = 9'd1;
      end
    end else begin
      play_slot(next_note);
      next_note = next_note + 9'd1;
    end
  endfunction

  function automatic result_t pwm_after_word(logic [2:0] op, logic [7:0] idx,
                                             logic [15:0] freq, logic [15:0] dur,
                                             logic [7:0] loops);
    result_t res;
    case (op)
      OP_WRITE_NOTE: begin
        note_tbl[idx] = {freq, dur};
      end
      OP_START: begin
        silence();
        pass_no = '0;
        last_pass = ((loops == 8'd0) ? 8'd1 : loops) - 8'd1;
        next_note = '0;
        if (notes_in_use() == 0) begin
          in_tune = 1'b0;
        end else begin
          in_tune = 1'b1;
          play_slot(9'd0);
          next_note = 9'd1;
        end
      end
      OP_STOP: begin
        in_tune = 1'b0;
        silence();
      end
      OP_TICK: begin
        if (counting) begin
          ticks_rem = ticks_rem - 16'd1;
          if (ticks_rem == 16'd0) note_done();
        end
      end
      OP_TONE: begin
        in_tune = 1'b0;
        sound_note(freq, dur);
      end
      default: begin
      end
    endcase
    res.tone_on = buzz_on;
    res.reload_value = buzz_on ? buzz_reload : 16'd0;
    res.compare_value = buzz_on ? buzz_cmp : 16'd0;
    res.playing = in_tune;
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t due;
    if (rst) begin
      clk_rate = CLOCK_HZ_RESET;
      tune_len = '0;
      next_note = '0;
      pass_no = '0;
      last_pass = '0;
      in_tune = 1'b0;
      silence();
      pwm_due_q.delete();
      mismatches = 0;
    end else begin
      if (write_enable) begin
        if (register_index == REG_CLOCK_HZ) clk_rate = write_data;
        else tune_len = write_data[8:0];
      end
      if (pop && !empty) begin
        if (pwm_due_q.size() == 0) begin
          $error("result word with none due: tone_on %0d reload %0d compare %0d playing %0d",
                 tone_on, reload_value, compare_value, playing);
          mismatches++;
        end else begin
          due = pwm_due_q.pop_front();
          check_field("tone_on", 16'(due.tone_on), 16'(tone_on));
          check_field("reload_value", due.reload_value, reload_value);
          check_field("compare_value", due.compare_value, compare_value);
          check_field("playing", 16'(due.playing), 16'(playing));
        end
      end
      if (push && !full) begin
        pwm_due_q.push_back(pwm_after_word(operation, note_index, note_frequency,
                                           note_duration, loop_count));
      end
    end
    words_due = pwm_due_q.size();
  end

endmodule

[dv/pwm_buzzer_melody_sequencer_top_tb.sv]
`timescale 1ns / 1ps

module pwm_buzzer_melody_sequencer_top_tb;
  import bmel_pkg::*;

  localparam logic [2:0] OP_UNUSED_TOP = 3'd7;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  operation;
  logic [7:0]  note_index;
  logic [15:0] note_frequency;
  logic [15:0] note_duration;
  logic [7:0]  loop_count;
  logic        empty;
  logic        pop;
  logic        tone_on;
  logic [15:0] reload_value;
  logic [15:0] compare_value;
  logic        playing;
  logic        write_enable;
  logic        register_index;
  logic [31:0] write_data;
  int          mismatches;
  int          words_due;
  bit          steady;
  bit          squeeze;
  bit          squeezed;

  pwm_buzzer_melody_sequencer_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .note_index     (note_index),
    .note_frequency (note_frequency),
    .note_duration  (note_duration),
    .loop_count     (loop_count),
    .empty          (empty),
    .pop            (pop),
    .tone_on        (tone_on),
    .reload_value   (reload_value),
    .compare_value  (compare_value),
    .playing        (playing),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  pwm_buzzer_melody_sequencer_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .note_index     (note_index),
    .note_frequency (note_frequency),
    .note_duration  (note_duration),
    .loop_count     (loop_count),
    .empty          (empty),
    .pop            (pop),
    .tone_on        (tone_on),
    .reload_value   (reload_value),
    .compare_value  (compare_value),
    .playing        (playing),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .mismatches     (mismatches),
    .words_due      (words_due)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #8_000_000;
    $display("pwm_buzzer_melody_sequencer_top: mismatch");
    $finish;
  end

  // Called and returning at a falling edge.
  task automatic send_word(input logic [2:0] op, input logic [7:0] idx,
                           input logic [15:0] freq, input logic [15:0] dur,
                           input logic [7:0] loops);
    while (!steady && $urandom_range(99) < 33) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    operation = op;
    note_index = idx;
    note_frequency = freq;
    note_duration = dur;
    loop_count = loops;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Operations whose other fields are don't-care get random noise there.
  task automatic send_op(input logic [2:0] op);
    send_word(op, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] value);
    write_enable = 1'b1;
    register_index = idx;
    write_data = value;
    @(negedge clk);
    write_enable = 1'b0;
  endtask

  task automatic settle();
    push = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (48) @(negedge clk);
  endtask

  function automatic logic [15:0] any_freq();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(20, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] any_dur();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_op(OP_TICK);
    end else if (pick < 58) begin
      send_word(OP_WRITE_NOTE,
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)),
                any_freq(), any_dur(), 8'($urandom));
    end else if (pick < 72) begin
      send_word(OP_START, 8'($urandom), 16'($urandom), 16'($urandom),
                ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
    end else if (pick < 80) begin
      send_op(OP_STOP);
    end else if (pick < 94) begin
      send_word(OP_TONE, 8'($urandom), any_freq(), any_dur(), 8'($urandom));
    end else begin
      send_op(3'($urandom_range(OP_TONE + 3'd1, OP_UNUSED_TOP)));
    end
  endtask

  // Result side: random pops, and one long hold-off while the sender keeps
  // pushing so that both queues fill and full rises.
  initial begin
    pop = 1'b0;
    squeezed = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        pop = 1'b0;
        repeat (300) @(negedge clk);
        squeezed = 1'b1;
      end
      pop = steady || ($urandom_range(99) >= 33);
      @(negedge clk);
    end
  end

  initial begin
    int ph;
    rst = 1'b1;
    push = 1'b0;
    operation = OP_WRITE_NOTE;
    note_index = '0;
    note_frequency = '0;
    note_duration = '0;
    loop_count = '0;
    write_enable = 1'b0;
    register_index = REG_CLOCK_HZ;
    write_data = '0;
    steady = 1'b0;
    squeeze = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Words that do nothing from idle.
    send_op(OP_TICK);
    send_op(OP_TONE + 3'd1);
    send_op(OP_UNUSED_TOP);
    send_op(OP_STOP);
    // Single tones: rest, lowest and highest frequency, longest duration.
    send_word(OP_TONE, 8'd0, 16'd0, 16'd0, 8'd0);
    send_word(OP_TONE, 8'd0, 16'd1, 16'd0, 8'd0);
    send_word(OP_TONE, 8'd0, 16'hFFFF, 16'hFFFF, 8'd0);
    send_word(OP_TONE, 8'd0, 16'd440, 16'd2, 8'd0);
    send_op(OP_TICK);
    send_op(OP_TICK);
    // A four-note tune with a rest in it, plus the top table slot.
    send_word(OP_WRITE_NOTE, 8'd0, 16'd262, 16'd1, 8'd0);
    send_word(OP_WRITE_NOTE, 8'd1, 16'd0, 16'd2, 8'd0);
    send_word(OP_WRITE_NOTE, 8'd2, 16'hFFFF, 16'd1, 8'd0);
    send_word(OP_WRITE_NOTE, 8'd3, 16'd1, 16'd1, 8'd0);
    send_word(OP_WRITE_NOTE, 8'hFF, 16'd2000, 16'd1, 8'hFF);
    // The melody length is still zero, so start stays silent.
    send_word(OP_START, 8'd0, 16'd0, 16'd0, 8'd3);
    settle();
    set_reg(REG_TUNE_LENGTH, 32'd4);
    // A loop count of zero plays the tune once.
    send_word(OP_START, 8'd0, 16'd0, 16'd0, 8'd0);
    repeat (5) send_op(OP_TICK);
    send_word(OP_START, 8'd0, 16'd0, 16'd0, 8'hFF);
    send_op(OP_TICK);
    send_word(OP_TONE, 8'd0, 16'd880, 16'd0, 8'd0);
    send_word(OP_START, 8'd0, 16'd0, 16'd0, 8'd2);
    send_op(OP_STOP);

    // Fill the whole table back to back with no idling.
    settle();
    steady = 1'b1;
    for (int i = 0; i < 256; i++) begin
      send_word(OP_WRITE_NOTE, 8'(i),
                ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom), 16'd1, 8'($urandom));
    end
    steady = 1'b0;

    // An over-long melody length acts as the full table; play one full pass
    // while the result side holds off for a while.
    settle();
    set_reg(REG_TUNE_LENGTH, 32'd511);
    send_word(OP_START, 8'($urandom), 16'($urandom), 16'($urandom), 8'd1);
    squeeze = 1'b1;
    repeat (260) send_op(OP_TICK);

    for (ph = 0; ph < 10; ph++) begin
      settle();
      case (ph % 5)
        0: set_reg(REG_CLOCK_HZ, 32'd1);
        1: set_reg(REG_CLOCK_HZ, 32'd0);
        2: set_reg(REG_CLOCK_HZ, 32'hFFFF_FFFF);
        3: set_reg(REG_CLOCK_HZ, CLOCK_HZ_RESET);
        default: set_reg(REG_CLOCK_HZ, $urandom);
      endcase
      case (ph % 4)
        0: set_reg(REG_TUNE_LENGTH, $urandom_range(1, 6));
        1: set_reg(REG_TUNE_LENGTH, 32'd0);
        2: set_reg(REG_TUNE_LENGTH, 32'd256);
        default: set_reg(REG_TUNE_LENGTH, $urandom_range(1, 16));
      endcase
      repeat (30) random_word();
    end

    settle();
    if (mismatches == 0) begin
      $display("pwm_buzzer_melody_sequencer_top: match");
    end else begin
      $display("pwm_buzzer_melody_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule

[pwm_buzzer_melody_sequencer_top.f]
hw/rtl/bmel_pkg.sv
hw/rtl/bmel_fifo.sv
hw/rtl/bmel_front.sv
hw/rtl/bmel_back.sv
hw/rtl/pwm_buzzer_melody_sequencer_top.sv
dv/pwm_buzzer_melody_sequencer_checker.sv
dv/pwm_buzzer_melody_sequencer_top_tb.sv
